/* design/sstt_pkg.sv */
// Package for the sensor self-test tachometer.
// Holds the codes, sequencer states, arithmetic unit control types and fixed constants.
// No dependencies.
package sstt_pkg;

  // operation carried in tuser
  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PULSE   = 2'd1,
    OP_ACCEL   = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  // self-test phase
  typedef enum logic [2:0] {
    PH_START      = 3'd0,
    PH_WAIT_WHEEL = 3'd1,
    PH_WAIT_SHAKE = 3'd2,
    PH_READY      = 3'd3,
    PH_RUNNING    = 3'd4,
    PH_FAILED     = 3'd5
  } phase_e;

  // per-sensor status
  typedef enum logic [1:0] {
    SS_UNKNOWN = 2'd0,
    SS_TESTING = 2'd1,
    SS_HEALTHY = 2'd2,
    SS_TIMEOUT = 2'd3
  } sens_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_WHEEL = 2'd1,
    ERR_ACCEL = 2'd2
  } err_e;

  // configuration register index
  typedef enum logic [2:0] {
    REG_WHEEL_TO   = 3'd0,
    REG_SHAKE_TO   = 3'd1,
    REG_STALE      = 3'd2,
    REG_SHAKE_THR  = 3'd3,
    REG_IMPACT_THR = 3'd4,
    REG_CIRC       = 3'd5
  } cfg_reg_e;

  // item sequencer
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_PREP,
    SQ_SQUARE,
    SQ_ROOT,
    SQ_DIV_RPM,
    SQ_DIV_SPD,
    SQ_APPLY
  } seq_e;

  typedef enum logic {
    AM_DIV  = 1'b0,
    AM_SQRT = 1'b1
  } arith_mode_e;

  typedef struct packed {
    logic        start;
    arith_mode_e mode;
  } arith_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_sts_t;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_BITS   = 34;
  localparam int RAD_W      = 32;
  localparam int ROOT_W     = 16;
  localparam int DIV_STEPS  = NUM_BITS;
  localparam int ROOT_STEPS = RAD_W / 2;
  localparam int CNT_W      = 6;
  localparam int LIM_W      = 26;
  localparam int RATE_W     = 24;
  localparam int OUT_W      = 128;
  localparam int USER_W     = 3;

  localparam logic [NUM_BITS-1:0] RPM_NUM   = 34'd6000000000;
  localparam logic [16:0]         SPD_SCALE = 17'd100000;
  localparam logic [9:0]          MS_TO_US  = 10'd1000;
  localparam logic [RATE_W-1:0]   SAT24     = 24'hFFFFFF;

endpackage

/* design/sstt_arith.sv */
// Shared iterative divide / square-root unit, one quotient or root bit per cycle.
// Depends on sstt_pkg.
module sstt_arith #(
  parameter int TIME_BITS = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sstt_pkg::arith_cmd_t           cmd_i,
  input  logic [sstt_pkg::NUM_BITS-1:0]  num_i,
  input  logic [TIME_BITS-1:0]           den_i,
  input  logic [sstt_pkg::RAD_W-1:0]     rad_i,
  output sstt_pkg::arith_sts_t           sts_o,
  output logic [sstt_pkg::NUM_BITS-1:0]  quot_o,
  output logic [sstt_pkg::ROOT_W-1:0]    root_o,
  output logic                           rem_nz_o
);
  import sstt_pkg::*;

  localparam int W = TIME_BITS + 2;

  logic [W-1:0]        rem_q, rem_d, shl, sub;
  logic [W:0]          diff;
  logic                ge, last;
  logic [NUM_BITS-1:0] acc_q, acc_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q, done_q;
  arith_mode_e         mode_q;

  // one restoring step: shared subtract and compare
  always_comb begin
    if (mode_q == AM_DIV) begin
      shl = {rem_q[W-2:0], acc_q[NUM_BITS-1]};
      sub = W'(den_i);
    end else begin
      shl = {rem_q[W-3:0], acc_q[NUM_BITS-1 -: 2]};
      sub = W'({root_q, 2'b01});
    end
    diff  = {1'b0, shl} - {1'b0, sub};
    ge    = ~diff[W];
    rem_d = ge ? diff[W-1:0] : shl;
    if (mode_q == AM_DIV) begin
      acc_d  = {acc_q[NUM_BITS-2:0], ge};
      root_d = root_q;
      last   = (cnt_q == CNT_W'(DIV_STEPS - 1));
    end else begin
      acc_d  = {acc_q[NUM_BITS-3:0], 2'b00};
      root_d = {root_q[ROOT_W-2:0], ge};
      last   = (cnt_q == CNT_W'(ROOT_STEPS - 1));
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= AM_DIV;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        mode_q <= cmd_i.mode;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rem_q  <= '0;
      root_q <= '0;
      acc_q  <= (cmd_i.mode == AM_DIV) ? num_i : {rad_i, {(NUM_BITS-RAD_W){1'b0}}};
    end else if (busy_q) begin
      rem_q  <= rem_d;
      acc_q  <= acc_d;
      root_q <= root_d;
    end
  end

  assign sts_o    = '{busy: busy_q, done: done_q};
  assign quot_o   = acc_q;
  assign root_o   = root_q;
  assign rem_nz_o = |rem_q;

endmodule

/* design/sensor_self_test_tachometer.sv */
// Sensor self-test tachometer: usage
// Input stream s_axis: one word per event. tuser holds the operation and the
// accel-valid flag, tdata the time stamp and the three raw acceleration axes.
// Output stream m_axis: one result word per input word, carrying phase,
// statuses, error, ready flags, rpm x100, speed, magnitude, impact and count.
// Configuration: write enable, index and 16-bit data, written while idle.
// Steps per word, with the shared divide / root unit (one bit per cycle):
//   restart and plain tick: prepare, then apply into the output register
//   accel sample (or tick with sample): prepare, squares of the three axes, then the root
//   hall pulse with a period: prepare, then two 34-step divisions (rpm, then speed)
// One word is worked on at a time; s_axis_tready is high only while idle,
// so a new word is accepted only once the result of the last one is applied.
// A finished word waits in the output register; the next word is accepted
// meanwhile, but its result is held back until the receiver takes the
// previous one, so a stalled receiver stalls the block after one word.
// Reset clears the sequencer and architectural state and loads the register
// defaults; no output is pending after reset.
// Depends on sstt_pkg and sstt_arith.
module sensor_self_test_tachometer #(
  parameter int TIME_BITS = 48
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // now_us, accel_x, accel_y, accel_z (lowest first), zero filled
  input  logic [((TIME_BITS+48+7)/8)*8-1:0] s_axis_tdata,
  // operation, accel_valid
  input  logic [sstt_pkg::USER_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // phase, wheel_status, accel_state, error_code, ready_res, command_allowed,
  // rpm_x100, speed_mm_s, magnitude, impact_level, impact_now, pulse_count
  output logic [sstt_pkg::OUT_W-1:0]        m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [sstt_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [sstt_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import sstt_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] wheel_to_q, shake_to_q, stale_q, shake_thr_q, impact_thr_q, circ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_to_q   <= 16'd10000;
      shake_to_q   <= 16'd20000;
      stale_q      <= 16'd2000;
      shake_thr_q  <= 16'd6144;
      impact_thr_q <= 16'd12288;
      circ_q       <= 16'd1916;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_WHEEL_TO:   wheel_to_q   <= cfg_wdata_i;
        REG_SHAKE_TO:   shake_to_q   <= cfg_wdata_i;
        REG_STALE:      stale_q      <= cfg_wdata_i;
        REG_SHAKE_THR:  shake_thr_q  <= cfg_wdata_i;
        REG_IMPACT_THR: impact_thr_q <= cfg_wdata_i;
        REG_CIRC:       circ_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer and captured word
  seq_e state_q, state_d;
  op_e  op_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 av_q;
  logic signed [15:0]   ax_q, ay_q, az_q;
  logic in_acc, commit;

  assign s_axis_tready = (state_q == SQ_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign commit        = (state_q == SQ_APPLY) && (!m_axis_tvalid || m_axis_tready);

  // architectural state
  phase_e phase_q, phase_d;
  sens_e  ws_q, ws_d, as_q, as_d;
  err_e   err_q, err_d;
  logic   valid_q, valid_d, rot_q, rot_d, shake_q, shake_d, ready_q, ready_d;
  logic   pseen_q, pseen_d;
  logic [TIME_BITS-1:0] start_q, start_d, lastp_q, lastp_d;
  logic [31:0]          cnt_q, cnt_d;
  logic [RATE_W-1:0]    rpm_q, rpm_d, spd_q, spd_d;
  logic [15:0]          mag_q, mag_d, imp_q, imp_d;
  logic                 imp_now;

  // prepared operands
  logic [TIME_BITS-1:0] elapsed_q, delta_q;
  logic                 dzero_q, acc_do_q, acc_do;
  logic [LIM_W-1:0]     wheel_lim_q, shake_lim_q, stale_lim_q;
  logic [NUM_BITS-1:0]  spd_num_q;
  logic [1:0]           sq_idx_q;
  logic signed [15:0]   sq_sel;
  logic [31:0]          prod_q, sum_q;
  logic [RATE_W-1:0]    rpm_new_q;

  // shared arithmetic unit
  arith_cmd_t           a_cmd;
  arith_sts_t           a_sts;
  logic [NUM_BITS-1:0]  a_num, a_quot;
  logic [ROOT_W-1:0]    a_root;
  logic                 a_rem_nz;

  // radicand includes the last square, still in prod_q when the root starts
  sstt_arith #(.TIME_BITS(TIME_BITS)) u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (a_cmd),
    .num_i    (a_num),
    .den_i    (delta_q),
    .rad_i    (sum_q + prod_q),
    .sts_o    (a_sts),
    .quot_o   (a_quot),
    .root_o   (a_root),
    .rem_nz_o (a_rem_nz)
  );

  assign acc_do = (op_q == OP_ACCEL) ||
                  ((op_q == OP_TICK) && av_q &&
                   ((phase_q == PH_WAIT_SHAKE) || (phase_q == PH_RUNNING)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SQ_IDLE:    if (in_acc) state_d = SQ_PREP;
      SQ_PREP: begin
        if (acc_do) state_d = SQ_SQUARE;
        else if ((op_q == OP_PULSE) && pseen_q && (now_q != lastp_q)) state_d = SQ_DIV_RPM;
        else state_d = SQ_APPLY;
      end
      SQ_SQUARE:  if (sq_idx_q == 2'd3) state_d = SQ_ROOT;
      SQ_ROOT:    if (a_sts.done) state_d = SQ_APPLY;
      SQ_DIV_RPM: if (a_sts.done) state_d = SQ_DIV_SPD;
      SQ_DIV_SPD: if (a_sts.done) state_d = SQ_APPLY;
      SQ_APPLY:   if (commit) state_d = SQ_IDLE;
      default:    state_d = SQ_IDLE;
    endcase
  end

  // unit commands
  always_comb begin
    a_cmd.start = (state_q != state_d) &&
                  ((state_d == SQ_ROOT) || (state_d == SQ_DIV_RPM) || (state_d == SQ_DIV_SPD));
    a_cmd.mode  = (state_d == SQ_ROOT) ? AM_SQRT : AM_DIV;
    a_num       = (state_d == SQ_DIV_SPD) ? spd_num_q : RPM_NUM;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SQ_IDLE;
    else         state_q <= state_d;
  end

  // word capture, operand preparation and squares
  always_comb begin
    unique case (sq_idx_q)
      2'd0:    sq_sel = ax_q;
      2'd1:    sq_sel = ay_q;
      default: sq_sel = az_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= op_e'(s_axis_tuser[1:0]);
      av_q <= s_axis_tuser[2];
      now_q <= s_axis_tdata[TIME_BITS-1:0];
      ax_q <= s_axis_tdata[TIME_BITS +: 16];
      ay_q <= s_axis_tdata[TIME_BITS+16 +: 16];
      az_q <= s_axis_tdata[TIME_BITS+32 +: 16];
    end
    if (state_q == SQ_PREP) begin
      elapsed_q   <= now_q - start_q;
      delta_q     <= now_q - lastp_q;
      dzero_q     <= (now_q == lastp_q);
      acc_do_q    <= acc_do;
      wheel_lim_q <= LIM_W'(wheel_to_q) * LIM_W'(MS_TO_US);
      shake_lim_q <= LIM_W'(shake_to_q) * LIM_W'(MS_TO_US);
      stale_lim_q <= LIM_W'(stale_q) * LIM_W'(MS_TO_US);
      spd_num_q   <= NUM_BITS'(circ_q) * NUM_BITS'(SPD_SCALE);
      sum_q       <= '0;
      sq_idx_q    <= '0;
    end
    if (state_q == SQ_SQUARE) begin
      prod_q   <= 32'(sq_sel) * 32'(sq_sel);
      sum_q    <= sum_q + ((sq_idx_q != 2'd0) ? prod_q : 32'd0);
      sq_idx_q <= sq_idx_q + 1'b1;
    end
    if ((state_q == SQ_DIV_RPM) && a_sts.done)
      rpm_new_q <= (a_quot > NUM_BITS'(SAT24)) ? SAT24 : a_quot[RATE_W-1:0];
  end

  // state update of one word
  logic shake_hit, impact_hit;
  assign shake_hit  = (a_root > shake_thr_q) || ((a_root == shake_thr_q) && a_rem_nz);
  assign impact_hit = (a_root > impact_thr_q) || ((a_root == impact_thr_q) && a_rem_nz);

  always_comb begin
    phase_d = phase_q; ws_d = ws_q; as_d = as_q; err_d = err_q;
    valid_d = valid_q; rot_d = rot_q; shake_d = shake_q; ready_d = ready_q;
    pseen_d = pseen_q; start_d = start_q; lastp_d = lastp_q; cnt_d = cnt_q;
    rpm_d = rpm_q; spd_d = spd_q; mag_d = mag_q; imp_d = imp_q;
    imp_now = 1'b0;
    // sample first, ahead of the shake check
    if (acc_do_q) begin
      mag_d = a_root;
      if (valid_q && shake_hit) shake_d = 1'b1;
      if (!valid_q && impact_hit) begin
        imp_d   = a_root;
        imp_now = 1'b1;
      end
    end
    unique case (op_q)
      OP_TICK: begin
        unique case (phase_q)
          PH_START: begin
            phase_d = PH_WAIT_WHEEL; ws_d = SS_TESTING; valid_d = 1'b1;
          end
          PH_WAIT_WHEEL: begin
            if (rot_q) begin
              ws_d = SS_HEALTHY; phase_d = PH_WAIT_SHAKE; as_d = SS_TESTING;
            end else if (elapsed_q > TIME_BITS'(wheel_lim_q)) begin
              ws_d = SS_TIMEOUT; phase_d = PH_FAILED; err_d = ERR_WHEEL;
            end
          end
          PH_WAIT_SHAKE: begin
            if (shake_d) begin
              as_d = SS_HEALTHY; phase_d = PH_READY;
            end else if (elapsed_q > TIME_BITS'(shake_lim_q)) begin
              as_d = SS_TIMEOUT; phase_d = PH_FAILED; err_d = ERR_ACCEL;
            end
          end
          PH_READY: begin
            ready_d = 1'b1; phase_d = PH_RUNNING; valid_d = 1'b0;
          end
          PH_RUNNING: begin
            if (pseen_q && (delta_q > TIME_BITS'(stale_lim_q))) begin
              rpm_d = '0; spd_d = '0;
            end
          end
          PH_FAILED: ready_d = 1'b0;
          default: ;
        endcase
      end
      OP_PULSE: begin
        cnt_d = cnt_q + 1'b1;
        if (pseen_q && !dzero_q) begin
          rpm_d = rpm_new_q;
          spd_d = (a_quot > NUM_BITS'(SAT24)) ? SAT24 : a_quot[RATE_W-1:0];
        end
        lastp_d = now_q;
        pseen_d = 1'b1;
        if (valid_q) rot_d = 1'b1;
      end
      OP_ACCEL: ;
      OP_RESTART: begin
        phase_d = PH_START; ws_d = SS_UNKNOWN; as_d = SS_UNKNOWN; err_d = ERR_NONE;
        start_d = now_q; ready_d = 1'b0; rot_d = 1'b0; shake_d = 1'b0;
        cnt_d = '0; rpm_d = '0; spd_d = '0; mag_d = '0; imp_d = '0; valid_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START; ws_q <= SS_UNKNOWN; as_q <= SS_UNKNOWN; err_q <= ERR_NONE;
      valid_q <= 1'b0; rot_q <= 1'b0; shake_q <= 1'b0; ready_q <= 1'b0;
      pseen_q <= 1'b0; start_q <= '0; lastp_q <= '0; cnt_q <= '0;
      rpm_q <= '0; spd_q <= '0; mag_q <= '0; imp_q <= '0;
    end else if (commit) begin
      phase_q <= phase_d; ws_q <= ws_d; as_q <= as_d; err_q <= err_d;
      valid_q <= valid_d; rot_q <= rot_d; shake_q <= shake_d; ready_q <= ready_d;
      pseen_q <= pseen_d; start_q <= start_d; lastp_q <= lastp_d; cnt_q <= cnt_d;
      rpm_q <= rpm_d; spd_q <= spd_d; mag_q <= mag_d; imp_q <= imp_d;
    end
  end

  // output register
  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            out_valid_q <= 1'b0;
    else if (commit)        out_valid_q <= 1'b1;
    else if (m_axis_tready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (commit)
      out_data_q <= {4'b0, cnt_d, imp_now, imp_d, mag_d, spd_d, rpm_d,
                     ready_d & pseen_d, ready_d, err_d, as_d, ws_d, phase_d};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* design/sstt_checker.sv */
// Port-level checker for the sensor self-test tachometer, bound to the top level.
// Depends on sstt_pkg and sensor_self_test_tachometer.
module sstt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [sstt_pkg::OUT_W-1:0] m_axis_tdata
);
  import sstt_pkg::*;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result word dropped while stalled");

  // one word at a time: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // ready only in running phase
  a_ready_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[9] |-> m_axis_tdata[2:0] == PH_RUNNING)
    else $error("ready outside running phase");

  // commands allowed only when ready
  a_cmd_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[9])
    else $error("command allowed while not ready");

  // an error code goes with the failed phase
  a_err_failed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[8:7] != ERR_NONE) |-> m_axis_tdata[2:0] == PH_FAILED)
    else $error("error code outside failed phase");

endmodule

bind sensor_self_test_tachometer sstt_checker u_sstt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
